// ----- src/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, mode codes and controller/datapath interface types for the
// LFU block cache tag engine.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;

    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int CAP_BITS   = 5;
    localparam int CMP_BITS   = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
    localparam int FILE_BITS  = 16;
    localparam int OFF_BITS   = 48;
    localparam int SLOT_BITS  = 4;
    localparam int UCNT_BITS  = 16;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_MATCH = 2'd0;   // lookup: oldest matching tag
    localparam mode_t MODE_MIN   = 2'd1;   // insert: victim with lowest count
    localparam mode_t MODE_FREE  = 2'd2;   // insert: lowest free entry

    typedef struct packed {
        logic  load;
        logic  clear;
        logic  scan_en;
        logic  exec;
        mode_t mode;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic evict_needed;
    } dp_stat_t;

    function automatic logic [SLOT_BITS-1:0] to_slot(input logic [IDX_BITS-1:0] idx);
        logic [31:0] t;
        t = 32'(idx);
        return t[SLOT_BITS-1:0];
    endfunction

    function automatic logic [UCNT_BITS-1:0] to_ucnt(input logic [COUNT_BITS-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[UCNT_BITS-1:0];
    endfunction

endpackage

// ----- src/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: picks the scan mode per request, steps the entry scan and
// triggers the final update cycle.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cmd,
    input  lfu_pkg::dp_stat_t stat,
    output lfu_pkg::dp_cmd_t  dp_cmd,
    output logic             busy
);
    import lfu_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;
    mode_t      mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_MATCH;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        dp_cmd.load    = 1'b0;
        dp_cmd.clear   = 1'b0;
        dp_cmd.scan_en = 1'b0;
        dp_cmd.exec    = 1'b0;
        dp_cmd.mode    = mode_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    if (cmd == CMD_INSERT)
                        mode_next = stat.evict_needed ? MODE_MIN : MODE_FREE;
                    else
                        mode_next = MODE_MATCH;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                dp_cmd.scan_en = 1'b1;
                if (stat.scan_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // no valid victim found: fall back to a free-entry scan
                if (mode_reg == MODE_MIN && !stat.found)
                begin
                    dp_cmd.clear = 1'b1;
                    mode_next    = MODE_FREE;
                    state_next   = S_SCAN;
                end
                else
                begin
                    dp_cmd.exec = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef NO_ASSERTIONS
    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !stat.scan_last) |=> (state_reg == S_SCAN))
        else $error("scan left before last entry");
    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");
`endif

endmodule

// ----- src/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// lfu_dp
// Tag store, use counts, age ranks and occupancy, with the per-entry scan
// unit and the result registers.
// ----------------------------------------------------------------------------
module lfu_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lfu_pkg::dp_cmd_t                  dp_cmd,
    output lfu_pkg::dp_stat_t                 stat,
    input  logic [lfu_pkg::FILE_BITS-1:0]     file_id,
    input  logic [lfu_pkg::OFF_BITS-1:0]      block_offset,
    input  logic                              cfg_valid,
    input  logic [lfu_pkg::CAP_BITS-1:0]      cfg_data,
    output logic                              done,
    output logic                              hit,
    output logic [lfu_pkg::SLOT_BITS-1:0]     slot,
    output logic [lfu_pkg::UCNT_BITS-1:0]     use_count,
    output logic                              evicted,
    output logic [lfu_pkg::FILE_BITS-1:0]     victim_file_id,
    output logic [lfu_pkg::OFF_BITS-1:0]      victim_offset
);
    import lfu_pkg::*;

    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // entry store
    logic [ENTRIES-1:0]    entry_valid_reg;
    logic [FILE_BITS-1:0]  entry_file_reg   [ENTRIES];
    logic [OFF_BITS-1:0]   entry_offset_reg [ENTRIES];
    logic [COUNT_BITS-1:0] entry_count_reg  [ENTRIES];
    logic [IDX_BITS-1:0]   entry_rank_reg   [ENTRIES];
    logic [OCC_BITS-1:0]   occ_reg;
    logic [CAP_BITS-1:0]   cap_reg;

    // request and scan state
    logic [FILE_BITS-1:0]  req_file_reg;
    logic [OFF_BITS-1:0]   req_off_reg;
    logic [IDX_BITS-1:0]   scan_idx_reg;
    logic                  found_reg;
    logic [IDX_BITS-1:0]   sel_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [IDX_BITS-1:0]   best_rank_reg;

    // result registers
    logic                  done_reg;
    logic                  hit_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [UCNT_BITS-1:0]  use_count_reg;
    logic                  evicted_reg;
    logic [FILE_BITS-1:0]  victim_file_reg;
    logic [OFF_BITS-1:0]   victim_off_reg;

    logic [IDX_BITS-1:0]   rd_idx;
    logic                  rd_valid;
    logic [FILE_BITS-1:0]  rd_file;
    logic [OFF_BITS-1:0]   rd_off;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [IDX_BITS-1:0]   rd_rank;
    logic                  take;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CMP_BITS-1:0]   cap_w, occ_w, eff_cap;
    logic                  is_evict;

    assign rd_idx   = dp_cmd.exec ? sel_reg : scan_idx_reg;
    assign rd_valid = entry_valid_reg[rd_idx];
    assign rd_file  = entry_file_reg[rd_idx];
    assign rd_off   = entry_offset_reg[rd_idx];
    assign rd_cnt   = entry_count_reg[rd_idx];
    assign rd_rank  = entry_rank_reg[rd_idx];

    assign cnt_inc  = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_ONE;
    assign is_evict = (dp_cmd.mode == MODE_MIN);

    always_comb
    begin
        cap_w = CMP_BITS'(cap_reg);
        occ_w = CMP_BITS'(occ_reg);
        priority if (cap_reg == '0)
            eff_cap = CMP_BITS'(1);
        else if (cap_w > CMP_BITS'(ENTRIES))
            eff_cap = CMP_BITS'(ENTRIES);
        else
            eff_cap = cap_w;
    end

    // does the entry under the scan pointer beat the best so far
    always_comb
    begin
        unique case (dp_cmd.mode)
            MODE_MATCH:
                take = rd_valid && rd_file == req_file_reg && rd_off == req_off_reg &&
                       (!found_reg || rd_rank < best_rank_reg);
            MODE_MIN:
                take = rd_valid && (!found_reg || rd_cnt < best_cnt_reg ||
                       (rd_cnt == best_cnt_reg && rd_rank < best_rank_reg));
            MODE_FREE:
                take = !rd_valid && !found_reg;
            default:
                take = 1'b0;
        endcase
    end

    assign stat.scan_last    = (scan_idx_reg == LAST_IDX);
    assign stat.found        = found_reg;
    assign stat.evict_needed = (occ_w >= eff_cap) && (occ_w != '0);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            req_file_reg <= file_id;
            req_off_reg  <= block_offset;
        end
    end

    // scan pointer and running best
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (dp_cmd.load || dp_cmd.clear)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (dp_cmd.scan_en)
        begin
            scan_idx_reg <= stat.scan_last ? '0 : scan_idx_reg + IDX_BITS'(1);
            if (take)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.scan_en && take)
        begin
            sel_reg       <= scan_idx_reg;
            best_cnt_reg  <= rd_cnt;
            best_rank_reg <= rd_rank;
        end
    end

    // config register and control part of the entry store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= CAP_RESET;
            occ_reg         <= '0;
            entry_valid_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= dp_cmd.exec;
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (dp_cmd.exec && dp_cmd.mode != MODE_MATCH && found_reg)
            begin
                entry_valid_reg[sel_reg] <= 1'b1;
                if (!is_evict)
                    occ_reg <= occ_reg + OCC_BITS'(1);
            end
        end
    end

    // payload part of the entry store
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec && found_reg)
        begin
            if (dp_cmd.mode == MODE_MATCH)
                entry_count_reg[sel_reg] <= cnt_inc;
            else
            begin
                if (is_evict)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (entry_valid_reg[i] && entry_rank_reg[i] > rd_rank)
                            entry_rank_reg[i] <= entry_rank_reg[i] - IDX_BITS'(1);
                    end
                end
                entry_file_reg[sel_reg]   <= req_file_reg;
                entry_offset_reg[sel_reg] <= req_off_reg;
                entry_count_reg[sel_reg]  <= COUNT_ONE;
                // youngest rank: occupancy after any eviction
                entry_rank_reg[sel_reg]   <= is_evict ? IDX_BITS'(occ_reg - OCC_BITS'(1))
                                                      : IDX_BITS'(occ_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            hit_reg         <= 1'b0;
            slot_reg        <= '0;
            use_count_reg   <= '0;
            evicted_reg     <= 1'b0;
            victim_file_reg <= '0;
            victim_off_reg  <= '0;
            if (found_reg)
            begin
                slot_reg <= to_slot(sel_reg);
                if (dp_cmd.mode == MODE_MATCH)
                begin
                    hit_reg       <= 1'b1;
                    use_count_reg <= to_ucnt(cnt_inc);
                end
                else
                begin
                    use_count_reg <= to_ucnt(COUNT_ONE);
                    if (is_evict)
                    begin
                        evicted_reg     <= 1'b1;
                        victim_file_reg <= rd_file;
                        victim_off_reg  <= rd_off;
                    end
                end
            end
        end
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign slot           = slot_reg;
    assign use_count      = use_count_reg;
    assign evicted        = evicted_reg;
    assign victim_file_id = victim_file_reg;
    assign victim_offset  = victim_off_reg;

`ifndef NO_ASSERTIONS
    a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        OCC_BITS'($countones(entry_valid_reg)) == occ_reg)
        else $error("occupancy out of step with valid entries");
    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.exec && found_reg && dp_cmd.mode != MODE_MATCH)
        |=> entry_valid_reg[$past(sel_reg)])
        else $error("insert did not leave its slot valid");
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (!evicted_reg && use_count_reg != '0))
        else $error("lookup hit with bad count or eviction");
`endif

endmodule

// ----- src/lfu_block_cache_tags.sv -----
// ----------------------------------------------------------------------------
// lfu_block_cache_tags
// Tag and LFU replacement engine for a fully associative block cache.
// ----------------------------------------------------------------------------
// Timing: done pulses after the start transfer, once one sequential scan
//   over the entry store and the finish state have run (done is registered).
// Throughput: one request at a time, busy until done; a new start is taken in the
//   cycle done is high. An eviction always finds a valid victim, so no rescan.
// Reset: all entries invalid, occupancy 0, capacity 16; results never stall.
module lfu_block_cache_tags (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [lfu_pkg::FILE_BITS-1:0]     file_id,
    input  logic [lfu_pkg::OFF_BITS-1:0]      block_offset,
    output logic                              done,
    output logic                              hit,
    output logic [lfu_pkg::SLOT_BITS-1:0]     slot,
    output logic [lfu_pkg::UCNT_BITS-1:0]     use_count,
    output logic                              evicted,
    output logic [lfu_pkg::FILE_BITS-1:0]     victim_file_id,
    output logic [lfu_pkg::OFF_BITS-1:0]      victim_offset,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfu_pkg::CAP_BITS-1:0]      cfg_data
);
    import lfu_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .stat   (stat),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    lfu_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .stat           (stat),
        .file_id        (file_id),
        .block_offset   (block_offset),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .done           (done),
        .hit            (hit),
        .slot           (slot),
        .use_count      (use_count),
        .evicted        (evicted),
        .victim_file_id (victim_file_id),
        .victim_offset  (victim_offset)
    );

endmodule
